// ===== sv/psla_pkg.sv =====
// Shared types and constants of the point and spot light accumulator.
// Holds the sequencer state type, the request and register codes and the arctangent table.
// Depends on nothing.
package psla_pkg;

   typedef enum logic [19:0] {
      ST_IDLE  = 20'h00001,
      ST_READ  = 20'h00002,
      ST_LOAD  = 20'h00004,
      ST_SQ    = 20'h00008,
      ST_SUM   = 20'h00010,
      ST_DSQRT = 20'h00020,
      ST_DCMP  = 20'h00040,
      ST_DIV1  = 20'h00080,
      ST_ROOT  = 20'h00100,
      ST_POW   = 20'h00200,
      ST_ANG   = 20'h00400,
      ST_CORD  = 20'h00800,
      ST_ADIFF = 20'h01000,
      ST_DIV2  = 20'h02000,
      ST_SPOT  = 20'h04000,
      ST_MULC  = 20'h08000,
      ST_MULA  = 20'h10000,
      ST_ACC   = 20'h20000,
      ST_NEXT  = 20'h40000,
      ST_FIN   = 20'h80000
   } state_type;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   localparam logic [1:0] KIND_POINT = 2'd1;
   localparam logic [1:0] KIND_SPOT  = 2'd2;

   localparam logic [1:0] CSR_AMBIENT_RED   = 2'd0;
   localparam logic [1:0] CSR_AMBIENT_GREEN = 2'd1;
   localparam logic [1:0] CSR_AMBIENT_BLUE  = 2'd2;

   localparam logic [16:0] ONE_Q16 = 17'h10000;

   function automatic logic [15:0] atan_entry(input logic [3:0] i);
      logic [15:0] v;
      case (i)
         4'd0: v = 16'd8192;
         4'd1: v = 16'd4836;
         4'd2: v = 16'd2555;
         4'd3: v = 16'd1297;
         4'd4: v = 16'd651;
         4'd5: v = 16'd326;
         4'd6: v = 16'd163;
         4'd7: v = 16'd81;
         4'd8: v = 16'd41;
         4'd9: v = 16'd20;
         4'd10: v = 16'd10;
         4'd11: v = 16'd5;
         4'd12: v = 16'd3;
         4'd13: v = 16'd1;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/point_spot_light_accumulator_unit.sv =====
// Point and spot light accumulator: light table memories, shading sequencer, result register.
// Depends on psla_pkg.
//
// A load request writes one light entry and gives no response. A sample request
// walks all MAX_LIGHTS entries one after another through a single shared datapath and gives one
// RGB response. A disabled entry is skipped after its read, and one out of reach after the
// distance check; a spot light adds the angle steps to those of a point light. The walk is
// governed by the bit-serial square root and the shared restoring divider. A new request
// is taken while a finished response still waits to be taken.
module point_spot_light_accumulator_unit #(
   parameter int MAX_LIGHTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic [3:0]         req_light_index,
   input  logic [1:0]         req_light_kind,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [23:0]        req_color_rgb,
   input  logic [11:0]        req_intensity,
   input  logic [15:0]        req_radius,
   input  logic [7:0]         req_falloff,
   input  logic signed [15:0] req_direction,
   input  logic [15:0]        req_inner_angle,
   input  logic [15:0]        req_outer_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue
);

   localparam int IDX_W = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
   localparam int ACC_W = 38 + $clog2(MAX_LIGHTS + 1);

   logic [45:0] shade_mem [MAX_LIGHTS];
   logic [95:0] pc_mem [MAX_LIGHTS];
   logic [45:0] shade_rd_ff;
   logic [95:0] pc_rd_ff;
   logic        vld_rd_ff;

   psla_pkg::state_type state_ff, state_in;
   logic [MAX_LIGHTS-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [7:0] amb_r_ff, amb_r_in, amb_g_ff, amb_g_in, amb_b_ff, amb_b_in;
   logic signed [15:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [16:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [33:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [33:0] sq_v_ff, sq_v_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;
   logic [31:0] div_d_ff, div_d_in;
   logic [16:0] div_r_ff, div_r_in, div_v_ff, div_v_in;
   logic [4:0]  div_cnt_ff, div_cnt_in;
   logic [15:0] p_ff, p_in;
   logic [1:0]  root_cnt_ff, root_cnt_in;
   logic [16:0] pw_ff, pw_in;
   logic [2:0]  pb_ff, pb_in;
   logic        ph_ff, ph_in;
   logic [16:0] att_ff, att_in, aat_ff, aat_in;
   logic signed [27:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [3:0]  cc_ff, cc_in;
   logic [15:0] ang_ff, ang_in;
   logic [19:0] ci_r_ff, ci_r_in, ci_g_ff, ci_g_in, ci_b_ff, ci_b_in;
   logic [36:0] pr_r_ff, pr_r_in, pr_g_ff, pr_g_in, pr_b_ff, pr_b_in;
   logic [ACC_W-1:0] acc_r_ff, acc_r_in, acc_g_ff, acc_g_in, acc_b_ff, acc_b_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_r_ff, rsp_r_in, rsp_g_ff, rsp_g_in, rsp_b_ff, rsp_b_in;

   logic [8:0]  wr_ext;
   logic        wr_ok;
   logic        req_fire;
   logic [1:0]  kind;
   logic [33:0] sq_t, sq_v_nx, sq_r_nx;
   logic        sq_ge;
   logic [17:0] dv_rs, dv_rm;
   logic        dv_ge;
   logic [31:0] div_d_nx;
   logic [16:0] mul_b, pw_nx;
   logic [33:0] pw_rnd, sp_rnd;
   logic signed [27:0] x0, y0, xs, ys;
   logic [15:0] diff;
   logic [16:0] a_abs, a_in_diff;
   logic [ACC_W-1:0] rnd_r, rnd_g, rnd_b;

   function automatic logic [7:0] clamp_out(input logic [ACC_W-1:0] v);
      return (v[ACC_W-1:32] != '0) ? 8'hFF : v[31:24];
   endfunction

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == psla_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_r_ff;
   assign rsp_green = rsp_g_ff;
   assign rsp_blue  = rsp_b_ff;

   assign wr_ext = {5'b0, req_light_index};
   assign wr_ok  = wr_ext < 9'(MAX_LIGHTS);

   always_ff @(posedge clock) begin
      if (req_fire && req_type == psla_pkg::REQ_LOAD && wr_ok) begin
         shade_mem[wr_ext[IDX_W-1:0]] <= {req_falloff, req_intensity, req_color_rgb,
                                           req_light_kind};
         pc_mem[wr_ext[IDX_W-1:0]] <= {req_outer_angle, req_inner_angle, req_direction,
                                        req_radius, req_pos_y, req_pos_x};
      end
      shade_rd_ff <= shade_mem[k_ff];
      pc_rd_ff    <= pc_mem[k_ff];
      vld_rd_ff   <= valid_ff[k_ff];
   end

   assign kind = shade_rd_ff[1:0];

   always_comb begin
      sq_t    = sq_r_ff + sq_bit_ff;
      sq_ge   = sq_v_ff >= sq_t;
      sq_v_nx = sq_ge ? sq_v_ff - sq_t : sq_v_ff;
      sq_r_nx = sq_ge ? (sq_r_ff >> 1) + sq_bit_ff : sq_r_ff >> 1;

      dv_rs    = {div_r_ff, div_d_ff[31]};
      dv_ge    = dv_rs >= {1'b0, div_v_ff};
      dv_rm    = dv_ge ? dv_rs - {1'b0, div_v_ff} : dv_rs;
      div_d_nx = {div_d_ff[30:0], dv_ge};

      mul_b  = ph_ff ? {1'b0, p_ff} : pw_ff;
      pw_rnd = pw_ff * mul_b + 34'd32768;
      pw_nx  = pw_rnd[32:16];
      sp_rnd = att_ff * aat_ff + 34'd32768;

      x0 = {{3{dx_ff[16]}}, dx_ff, 8'b0};
      y0 = {{3{dy_ff[16]}}, dy_ff, 8'b0};
      xs = cx_ff >>> cc_ff;
      ys = cy_ff >>> cc_ff;

      diff      = ang_ff - pc_rd_ff[63:48];
      a_abs     = diff[15] ? psla_pkg::ONE_Q16 - {1'b0, diff} : {1'b0, diff};
      a_in_diff = a_abs - {1'b0, pc_rd_ff[79:64]};

      rnd_r = acc_r_ff + ACC_W'(32'h0080_0000);
      rnd_g = acc_g_ff + ACC_W'(32'h0080_0000);
      rnd_b = acc_b_ff + ACC_W'(32'h0080_0000);
   end

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      k_in = k_ff;
      amb_r_in = amb_r_ff;
      amb_g_in = amb_g_ff;
      amb_b_in = amb_b_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      sqx_in = sqx_ff;
      sqy_in = sqy_ff;
      sq_v_in = sq_v_ff;
      sq_r_in = sq_r_ff;
      sq_bit_in = sq_bit_ff;
      div_d_in = div_d_ff;
      div_r_in = div_r_ff;
      div_v_in = div_v_ff;
      div_cnt_in = div_cnt_ff;
      p_in = p_ff;
      root_cnt_in = root_cnt_ff;
      pw_in = pw_ff;
      pb_in = pb_ff;
      ph_in = ph_ff;
      att_in = att_ff;
      aat_in = aat_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      cc_in = cc_ff;
      ang_in = ang_ff;
      ci_r_in = ci_r_ff;
      ci_g_in = ci_g_ff;
      ci_b_in = ci_b_ff;
      pr_r_in = pr_r_ff;
      pr_g_in = pr_g_ff;
      pr_b_in = pr_b_ff;
      acc_r_in = acc_r_ff;
      acc_g_in = acc_g_ff;
      acc_b_in = acc_b_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_r_in = rsp_r_ff;
      rsp_g_in = rsp_g_ff;
      rsp_b_in = rsp_b_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            psla_pkg::CSR_AMBIENT_RED: amb_r_in = csr_data;
            psla_pkg::CSR_AMBIENT_GREEN: amb_g_in = csr_data;
            psla_pkg::CSR_AMBIENT_BLUE: amb_b_in = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         psla_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_type == psla_pkg::REQ_SAMPLE) begin
                  sx_in = req_pos_x;
                  sy_in = req_pos_y;
                  k_in = '0;
                  acc_r_in = ACC_W'({amb_r_ff, 24'b0});
                  acc_g_in = ACC_W'({amb_g_ff, 24'b0});
                  acc_b_in = ACC_W'({amb_b_ff, 24'b0});
                  state_in = psla_pkg::ST_READ;
               end else if (wr_ok) begin
                  valid_in[wr_ext[IDX_W-1:0]] = 1'b1;
               end
            end
         end
         psla_pkg::ST_READ: begin
            state_in = psla_pkg::ST_LOAD;
         end
         psla_pkg::ST_LOAD: begin
            if (vld_rd_ff && (kind == psla_pkg::KIND_POINT || kind == psla_pkg::KIND_SPOT)) begin
               dx_in = 17'(sx_ff) - 17'(signed'(pc_rd_ff[15:0]));
               dy_in = 17'(sy_ff) - 17'(signed'(pc_rd_ff[31:16]));
               state_in = psla_pkg::ST_SQ;
            end else begin
               state_in = psla_pkg::ST_NEXT;
            end
         end
         psla_pkg::ST_SQ: begin
            sqx_in = 34'(dx_ff * dx_ff);
            sqy_in = 34'(dy_ff * dy_ff);
            state_in = psla_pkg::ST_SUM;
         end
         psla_pkg::ST_SUM: begin
            sq_v_in = sqx_ff + sqy_ff;
            sq_r_in = '0;
            sq_bit_in = 34'h1_0000_0000;
            state_in = psla_pkg::ST_DSQRT;
         end
         psla_pkg::ST_DSQRT: begin
            sq_v_in = sq_v_nx;
            sq_r_in = sq_r_nx;
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff[0]) begin
               state_in = psla_pkg::ST_DCMP;
            end
         end
         psla_pkg::ST_DCMP: begin
            if (sq_r_ff >= {18'b0, pc_rd_ff[47:32]} || shade_rd_ff[45:38] == 8'd0) begin
               state_in = psla_pkg::ST_NEXT;
            end else begin
               div_d_in = {sq_r_ff[15:0], 16'b0};
               div_r_in = '0;
               div_v_in = {1'b0, pc_rd_ff[47:32]};
               div_cnt_in = '0;
               state_in = psla_pkg::ST_DIV1;
            end
         end
         psla_pkg::ST_DIV1: begin
            div_d_in = div_d_nx;
            div_r_in = dv_rm[16:0];
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd31) begin
               sq_v_in = {2'b0, div_d_nx[15:0], 16'b0};
               sq_r_in = '0;
               sq_bit_in = 34'h1_0000_0000;
               root_cnt_in = '0;
               state_in = psla_pkg::ST_ROOT;
            end
         end
         psla_pkg::ST_ROOT: begin
            sq_v_in = sq_v_nx;
            sq_r_in = sq_r_nx;
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff[0]) begin
               p_in = sq_r_nx[15:0];
               root_cnt_in = root_cnt_ff + 2'd1;
               if (root_cnt_ff == 2'd3) begin
                  pw_in = psla_pkg::ONE_Q16;
                  pb_in = 3'd7;
                  ph_in = 1'b0;
                  state_in = psla_pkg::ST_POW;
               end else begin
                  sq_v_in = {2'b0, sq_r_nx[15:0], 16'b0};
                  sq_r_in = '0;
                  sq_bit_in = 34'h1_0000_0000;
               end
            end
         end
         psla_pkg::ST_POW: begin
            pw_in = pw_nx;
            if (!ph_ff && shade_rd_ff[6'd38 + 6'(pb_ff)]) begin
               ph_in = 1'b1;
            end else begin
               ph_in = 1'b0;
               pb_in = pb_ff - 3'd1;
               if (pb_ff == 3'd0) begin
                  att_in = psla_pkg::ONE_Q16 - pw_nx;
                  state_in = (kind == psla_pkg::KIND_SPOT) ? psla_pkg::ST_ANG
                                                           : psla_pkg::ST_MULC;
               end
            end
         end
         psla_pkg::ST_ANG: begin
            cc_in = '0;
            if (dx_ff == '0 && dy_ff == '0) begin
               ang_in = '0;
               state_in = psla_pkg::ST_ADIFF;
            end else begin
               if (x0 < 0) begin
                  cx_in = -x0;
                  cy_in = -y0;
                  ang_in = 16'h8000;
               end else begin
                  cx_in = x0;
                  cy_in = y0;
                  ang_in = '0;
               end
               state_in = psla_pkg::ST_CORD;
            end
         end
         psla_pkg::ST_CORD: begin
            if (cy_ff >= 0) begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               ang_in = ang_ff + psla_pkg::atan_entry(cc_ff);
            end else begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               ang_in = ang_ff - psla_pkg::atan_entry(cc_ff);
            end
            cc_in = cc_ff + 4'd1;
            if (cc_ff == 4'd13) begin
               state_in = psla_pkg::ST_ADIFF;
            end
         end
         psla_pkg::ST_ADIFF: begin
            if (a_abs > {1'b0, pc_rd_ff[95:80]}) begin
               state_in = psla_pkg::ST_NEXT;
            end else if (a_abs > {1'b0, pc_rd_ff[79:64]}) begin
               div_d_in = {a_in_diff[15:0], 16'b0};
               div_r_in = '0;
               div_v_in = {1'b0, pc_rd_ff[95:80]} - {1'b0, pc_rd_ff[79:64]};
               div_cnt_in = '0;
               state_in = psla_pkg::ST_DIV2;
            end else begin
               aat_in = psla_pkg::ONE_Q16;
               state_in = psla_pkg::ST_SPOT;
            end
         end
         psla_pkg::ST_DIV2: begin
            div_d_in = div_d_nx;
            div_r_in = dv_rm[16:0];
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd31) begin
               aat_in = psla_pkg::ONE_Q16 - div_d_nx[16:0];
               state_in = psla_pkg::ST_SPOT;
            end
         end
         psla_pkg::ST_SPOT: begin
            att_in = sp_rnd[32:16];
            state_in = psla_pkg::ST_MULC;
         end
         psla_pkg::ST_MULC: begin
            ci_r_in = shade_rd_ff[25:18] * shade_rd_ff[37:26];
            ci_g_in = shade_rd_ff[17:10] * shade_rd_ff[37:26];
            ci_b_in = shade_rd_ff[9:2] * shade_rd_ff[37:26];
            state_in = psla_pkg::ST_MULA;
         end
         psla_pkg::ST_MULA: begin
            pr_r_in = ci_r_ff * att_ff;
            pr_g_in = ci_g_ff * att_ff;
            pr_b_in = ci_b_ff * att_ff;
            state_in = psla_pkg::ST_ACC;
         end
         psla_pkg::ST_ACC: begin
            acc_r_in = acc_r_ff + ACC_W'(pr_r_ff);
            acc_g_in = acc_g_ff + ACC_W'(pr_g_ff);
            acc_b_in = acc_b_ff + ACC_W'(pr_b_ff);
            state_in = psla_pkg::ST_NEXT;
         end
         psla_pkg::ST_NEXT: begin
            if (k_ff == IDX_W'(MAX_LIGHTS - 1)) begin
               state_in = psla_pkg::ST_FIN;
            end else begin
               k_in = k_ff + IDX_W'(1);
               state_in = psla_pkg::ST_READ;
            end
         end
         psla_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_r_in = clamp_out(rnd_r);
               rsp_g_in = clamp_out(rnd_g);
               rsp_b_in = clamp_out(rnd_b);
               state_in = psla_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = psla_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psla_pkg::ST_IDLE;
         valid_ff <= '0;
         k_ff <= '0;
         amb_r_ff <= 8'd38;
         amb_g_ff <= 8'd38;
         amb_b_ff <= 8'd51;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         k_ff <= k_in;
         amb_r_ff <= amb_r_in;
         amb_g_ff <= amb_g_in;
         amb_b_ff <= amb_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      sq_v_ff <= sq_v_in;
      sq_r_ff <= sq_r_in;
      sq_bit_ff <= sq_bit_in;
      div_d_ff <= div_d_in;
      div_r_ff <= div_r_in;
      div_v_ff <= div_v_in;
      div_cnt_ff <= div_cnt_in;
      p_ff <= p_in;
      root_cnt_ff <= root_cnt_in;
      pw_ff <= pw_in;
      pb_ff <= pb_in;
      ph_ff <= ph_in;
      att_ff <= att_in;
      aat_ff <= aat_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cc_ff <= cc_in;
      ang_ff <= ang_in;
      ci_r_ff <= ci_r_in;
      ci_g_ff <= ci_g_in;
      ci_b_ff <= ci_b_in;
      pr_r_ff <= pr_r_in;
      pr_g_ff <= pr_g_in;
      pr_b_ff <= pr_b_in;
      acc_r_ff <= acc_r_in;
      acc_g_ff <= acc_g_in;
      acc_b_ff <= acc_b_in;
      rsp_r_ff <= rsp_r_in;
      rsp_g_ff <= rsp_g_in;
      rsp_b_ff <= rsp_b_in;
   end

endmodule

// ===== verif/tb_point_spot_light_accumulator_unit.sv =====
// Self-checking testbench of point_spot_light_accumulator_unit: light loads, samples and
// ambient register writes, with a directed table followed by random requests and random stalls.
// Depends on psla_pkg and point_spot_light_accumulator_unit.
`timescale 1ns / 1ps

module tb_point_spot_light_accumulator_unit;

   typedef struct {
      logic              kind_of_req;
      logic [3:0]        idx;
      logic [1:0]        kind;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [23:0]       color;
      logic [11:0]       inten;
      logic [15:0]       radius;
      logic [7:0]        fall;
      logic signed [15:0] dir;
      logic [15:0]       inner;
      logic [15:0]       outer;
   } light_req_type;

   typedef struct {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } rgb_type;

   typedef struct {
      light_req_type req;
      bit            typed;
      rgb_type       rgb;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = psla_pkg::CSR_AMBIENT_RED;
   logic [7:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = psla_pkg::REQ_LOAD;
   logic [3:0] req_light_index = '0;
   logic [1:0] req_light_kind = '0;
   logic signed [15:0] req_pos_x = '0;
   logic signed [15:0] req_pos_y = '0;
   logic [23:0] req_color_rgb = '0;
   logic [11:0] req_intensity = '0;
   logic [15:0] req_radius = '0;
   logic [7:0] req_falloff = '0;
   logic signed [15:0] req_direction = '0;
   logic [15:0] req_inner_angle = '0;
   logic [15:0] req_outer_angle = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;

   point_spot_light_accumulator_unit dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int PEND_DEPTH = 1024;
   localparam int ROW_DEPTH = 32;
   localparam longint ONE = 65536;
   localparam int ARCTAN [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5,
                                  3, 1};

   // Light table and ambient levels as the predictor sees them.
   logic [1:0]  lt_kind [16];
   logic [23:0] lt_color [16];
   logic [11:0] lt_inten [16];
   logic [7:0]  lt_fall [16];
   logic signed [15:0] lt_x [16];
   logic signed [15:0] lt_y [16];
   logic [15:0] lt_radius [16];
   logic [15:0] lt_dir [16];
   logic [15:0] lt_inner [16];
   logic [15:0] lt_outer [16];
   logic [7:0]  amb [3];

   rgb_type pending_rgb [PEND_DEPTH];
   int pend_wr = 0;
   int pend_rd = 0;
   table_row_type rows [ROW_DEPTH];
   int n_rows = 0;
   int failures = 0;
   int loads_sent = 0;
   int samples_sent = 0;
   int responses_seen = 0;
   int csr_writes = 0;
   int idle_cycles = 0;
   bit stall_free = 1'b0;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint q16_mul(longint a, longint b);
      return (a * b + 32768) >>> 16;
   endfunction

   function automatic longint reach_falloff(longint d, longint radius, logic [7:0] fall);
      longint t;
      longint p;
      longint pw = ONE;
      if (fall == 0) return 0;
      t = (d << 16) / radius;
      p = t;
      for (int i = 0; i < 4; i++) p = longint'(int_sqrt(longint'(p) << 16));
      for (int i = 7; i >= 0; i--) begin
         pw = q16_mul(pw, pw);
         if (fall[i]) pw = q16_mul(pw, p);
      end
      return ONE - pw;
   endfunction

   function automatic logic [15:0] bearing(longint dx, longint dy);
      longint x = dx * 256;
      longint y = dy * 256;
      longint xs;
      longint ys;
      longint ang = 0;
      if (dx == 0 && dy == 0) return 16'd0;
      if (x < 0) begin
         x = -x;
         y = -y;
         ang = 32768;
      end
      for (int i = 0; i < 14; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            ang = ang + ARCTAN[i];
         end else begin
            x = x - ys;
            y = y + xs;
            ang = ang - ARCTAN[i];
         end
      end
      return ang[15:0];
   endfunction

   function automatic rgb_type shade_point(logic signed [15:0] sx, logic signed [15:0] sy);
      longint acc [3];
      longint dx;
      longint dy;
      longint d;
      longint att;
      longint a;
      longint ang_att;
      logic [15:0] diff;
      longint res;
      rgb_type o;
      for (int c = 0; c < 3; c++) acc[c] = longint'(amb[c]) << 24;
      for (int k = 0; k < 16; k++) begin
         if (lt_kind[k] != psla_pkg::KIND_POINT && lt_kind[k] != psla_pkg::KIND_SPOT) continue;
         dx = longint'(sx) - longint'(lt_x[k]);
         dy = longint'(sy) - longint'(lt_y[k]);
         d = longint'(int_sqrt(dx * dx + dy * dy));
         if (d >= lt_radius[k]) continue;
         att = reach_falloff(d, lt_radius[k], lt_fall[k]);
         if (lt_kind[k] == psla_pkg::KIND_SPOT) begin
            diff = bearing(dx, dy) - lt_dir[k];
            a = diff[15] ? 65536 - longint'(diff) : longint'(diff);
            ang_att = ONE;
            if (a > lt_outer[k]) continue;
            if (a > lt_inner[k])
               ang_att = ONE - ((a - lt_inner[k]) << 16) / (lt_outer[k] - lt_inner[k]);
            att = (att * ang_att + 32768) >>> 16;
         end
         acc[0] += longint'(lt_color[k][23:16]) * lt_inten[k] * att;
         acc[1] += longint'(lt_color[k][15:8]) * lt_inten[k] * att;
         acc[2] += longint'(lt_color[k][7:0]) * lt_inten[k] * att;
      end
      for (int c = 0; c < 3; c++) begin
         res = (acc[c] + (longint'(1) << 23)) >>> 24;
         if (res > 255) res = 255;
         if (c == 0) o.r = res[7:0];
         else if (c == 1) o.g = res[7:0];
         else o.b = res[7:0];
      end
      return o;
   endfunction

   function automatic light_req_type load_req(int idx, logic [1:0] kind, int x, int y,
                                              logic [23:0] color, int inten, int radius,
                                              int fall, int dir, int inner, int outer);
      light_req_type q;
      q.kind_of_req = psla_pkg::REQ_LOAD;
      q.idx = idx[3:0];
      q.kind = kind;
      q.x = x[15:0];
      q.y = y[15:0];
      q.color = color;
      q.inten = inten[11:0];
      q.radius = radius[15:0];
      q.fall = fall[7:0];
      q.dir = dir[15:0];
      q.inner = inner[15:0];
      q.outer = outer[15:0];
      return q;
   endfunction

   function automatic light_req_type sample_req(int x, int y);
      light_req_type q = load_req(0, 2'd0, x, y, 24'h0, 0, 0, 0, 0, 0, 0);
      q.kind_of_req = psla_pkg::REQ_SAMPLE;
      q.idx = 4'($urandom);
      q.color = 24'($urandom);
      q.inten = 12'($urandom);
      return q;
   endfunction

   function automatic int scene_coord();
      if ($urandom_range(9) == 0) return $urandom_range(65535) - 32768;
      return $urandom_range(4095) - 2048;
   endfunction

   function automatic light_req_type random_req();
      light_req_type q;
      int roll = $urandom_range(99);
      logic [1:0] kind;
      int radius;
      int inner;
      int outer;
      if (roll < 25) return sample_req(scene_coord(), scene_coord());
      roll = $urandom_range(99);
      kind = roll < 20 ? 2'd0 : roll < 58 ? psla_pkg::KIND_POINT
           : roll < 95 ? psla_pkg::KIND_SPOT : 2'd3;
      radius = $urandom_range(4) == 0 ? $urandom_range(65535) : $urandom_range(8192);
      inner = $urandom_range(32768);
      outer = $urandom_range(32768);
      roll = $urandom_range(9);
      if (roll == 0) outer = inner;
      else if (roll == 1) outer = 32768;
      else if (roll == 2) inner = 0;
      q = load_req($urandom_range(15), kind, scene_coord(), scene_coord(), 24'($urandom),
                   $urandom_range(4095), radius, $urandom_range(255), $urandom_range(65535),
                   inner, outer);
      return q;
   endfunction

   function automatic void add_row(light_req_type q, bit typed, rgb_type rgb);
      rows[n_rows] = '{q, typed, rgb};
      n_rows++;
   endfunction

   task automatic send_request(light_req_type q, bit typed, rgb_type rgb);
      int gap;
      req_valid <= 1'b1;
      req_type <= q.kind_of_req;
      req_light_index <= q.idx;
      req_light_kind <= q.kind;
      req_pos_x <= q.x;
      req_pos_y <= q.y;
      req_color_rgb <= q.color;
      req_intensity <= q.inten;
      req_radius <= q.radius;
      req_falloff <= q.fall;
      req_direction <= q.dir;
      req_inner_angle <= q.inner;
      req_outer_angle <= q.outer;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (q.kind_of_req == psla_pkg::REQ_LOAD) begin
         lt_kind[q.idx] = q.kind;
         lt_color[q.idx] = q.color;
         lt_inten[q.idx] = q.inten;
         lt_fall[q.idx] = q.fall;
         lt_x[q.idx] = q.x;
         lt_y[q.idx] = q.y;
         lt_radius[q.idx] = q.radius;
         lt_dir[q.idx] = q.dir;
         lt_inner[q.idx] = q.inner;
         lt_outer[q.idx] = q.outer;
         loads_sent++;
      end else begin
         pending_rgb[pend_wr % PEND_DEPTH] = typed ? rgb : shade_point(q.x, q.y);
         pend_wr++;
         samples_sent++;
      end
      if (!stall_free && $urandom_range(3) == 0) begin
         gap = $urandom_range(19) == 0 ? $urandom_range(40, 10) : $urandom_range(3, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pend_rd != pend_wr) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_ambient(logic [1:0] idx, logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      amb[idx] = value;
      csr_writes++;
   endtask

   task automatic set_ambient(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      write_ambient(psla_pkg::CSR_AMBIENT_RED, r);
      write_ambient(psla_pkg::CSR_AMBIENT_GREEN, g);
      write_ambient(psla_pkg::CSR_AMBIENT_BLUE, b);
   endtask

   task automatic random_phase(int count);
      rgb_type none;
      none = '{8'd0, 8'd0, 8'd0};
      for (int i = 0; i < count; i++) send_request(random_req(), 1'b0, none);
   endtask

   always @(posedge clock) begin
      if (stall_free) begin
         rsp_ready <= 1'b1;
      end else if ($urandom_range(49) == 0) begin
         rsp_ready <= 1'b0;
      end else if (!rsp_ready && $urandom_range(3) != 0) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rgb_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (pend_rd == pend_wr) begin
            $error("unexpected response red=%0d green=%0d blue=%0d", rsp_red, rsp_green,
                   rsp_blue);
            failures++;
         end else begin
            want = pending_rgb[pend_rd % PEND_DEPTH];
            pend_rd++;
            if (rsp_red !== want.r) begin
               $error("red expected %0d actual %0d", want.r, rsp_red);
               failures++;
            end
            if (rsp_green !== want.g) begin
               $error("green expected %0d actual %0d", want.g, rsp_green);
               failures++;
            end
            if (rsp_blue !== want.b) begin
               $error("blue expected %0d actual %0d", want.b, rsp_blue);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      rgb_type ambient_rgb;
      rgb_type full_rgb;
      rgb_type none;
      ambient_rgb = '{8'd38, 8'd38, 8'd51};
      full_rgb = '{8'd255, 8'd255, 8'd255};
      none = '{8'd0, 8'd0, 8'd0};
      for (int k = 0; k < 16; k++) begin
         lt_kind[k] = 2'd0;
         lt_color[k] = '0;
         lt_inten[k] = '0;
         lt_fall[k] = '0;
         lt_x[k] = '0;
         lt_y[k] = '0;
         lt_radius[k] = '0;
         lt_dir[k] = '0;
         lt_inner[k] = '0;
         lt_outer[k] = '0;
      end
      amb[0] = 8'd38;
      amb[1] = 8'd38;
      amb[2] = 8'd51;

      add_row(sample_req(0, 0), 1'b1, ambient_rgb);
      add_row(load_req(0, psla_pkg::KIND_POINT, 0, 0, 24'hFFFFFF, 4095, 65535, 255, 0, 0, 0),
              1'b0, none);
      add_row(sample_req(0, 0), 1'b1, full_rgb);
      add_row(sample_req(32767, 32767), 1'b0, none);
      add_row(sample_req(-32768, -32768), 1'b0, none);
      add_row(load_req(0, 2'd0, 0, 0, 24'h0, 0, 0, 0, 0, 0, 0), 1'b0, none);
      add_row(load_req(1, psla_pkg::KIND_POINT, 0, 0, 24'hFFFFFF, 4095, 0, 16, 0, 0, 0),
              1'b0, none);
      add_row(sample_req(0, 0), 1'b1, ambient_rgb);
      add_row(load_req(1, psla_pkg::KIND_POINT, 0, 0, 24'hFFFFFF, 4095, 1000, 0, 0, 0, 0),
              1'b0, none);
      add_row(sample_req(10, 10), 1'b1, ambient_rgb);
      add_row(load_req(2, 2'd3, 0, 0, 24'hFFFFFF, 4095, 65535, 16, 0, 0, 0), 1'b0, none);
      add_row(sample_req(5, 5), 1'b1, ambient_rgb);
      add_row(load_req(2, psla_pkg::KIND_SPOT, 0, 0, 24'h808080, 256, 4000, 16, 0, 4096,
                       4096), 1'b0, none);
      add_row(sample_req(100, 0), 1'b0, none);
      add_row(sample_req(0, 100), 1'b0, none);
      add_row(sample_req(100, 60), 1'b0, none);
      add_row(load_req(2, psla_pkg::KIND_SPOT, 0, 0, 24'h40C020, 700, 4000, 40, 0, 8000,
                       2000), 1'b0, none);
      add_row(sample_req(100, 5), 1'b0, none);
      add_row(load_req(2, psla_pkg::KIND_SPOT, 0, 0, 24'hFF00FF, 300, 4000, 200, -32768, 0,
                       32768), 1'b0, none);
      add_row(sample_req(-100, 0), 1'b0, none);
      add_row(sample_req(100, 30), 1'b0, none);
      add_row(load_req(15, psla_pkg::KIND_POINT, -32768, 32767, 24'h00FF00, 4095, 65535, 255,
                       0, 0, 0), 1'b0, none);
      add_row(sample_req(-32768, 32767), 1'b0, none);
      add_row(load_req(15, 2'd0, 0, 0, 24'h0, 0, 0, 0, 0, 0, 0), 1'b0, none);
      add_row(load_req(2, 2'd0, 0, 0, 24'h0, 0, 0, 0, 0, 0, 0), 1'b0, none);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < n_rows; i++) send_request(rows[i].req, rows[i].typed, rows[i].rgb);
      drain_and_settle();

      set_ambient(8'd0, 8'd0, 8'd0);
      random_phase(300);
      drain_and_settle();
      set_ambient(8'd255, 8'd255, 8'd255);
      stall_free = 1'b1;
      random_phase(150);
      stall_free = 1'b0;
      random_phase(150);
      drain_and_settle();
      set_ambient(8'($urandom), 8'($urandom), 8'($urandom));
      random_phase(325);
      drain_and_settle();
      repeat (50) @(posedge clock);

      $display("Sent %0d light loads and %0d samples, checked %0d responses.", loads_sent,
               samples_sent, responses_seen);
      $display("Ambient levels were written %0d times, including both extremes.", csr_writes);
      if (failures == 0 && pend_rd == pend_wr) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/psla_pkg.sv
sv/point_spot_light_accumulator_unit.sv
verif/tb_point_spot_light_accumulator_unit.sv
